[hw/rtl/sis_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sis_pkg: shared types and constants
// Operation and status codes, field widths and default store depth.
// ----------------------------------------------------------------------------
package sis_pkg;
  localparam int unsigned DefaultMaxElements = 64;
  localparam int unsigned ValueWidth = 32;
  localparam int unsigned StatusWidth = 3;
  localparam int unsigned IndexWidth = 6;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SEARCH = 1'b1
  } op_t;

  typedef enum logic [StatusWidth-1:0] {
    ST_FOUND      = 3'd0,
    ST_NOT_FOUND  = 3'd1,
    ST_NOT_UNIFORM = 3'd2,
    ST_STORED     = 3'd3,
    ST_FULL       = 3'd4
  } status_t;
endpackage
`default_nettype wire

[hw/rtl/sis_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sis_in_if / sis_out_if: valid/ready channels
// Input item channel and result channel with source and sink views.
// ----------------------------------------------------------------------------
interface sis_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [31:0] value;
  logic        start_new;
  modport source (output valid, operation, value, start_new, input ready);
  modport sink (input valid, operation, value, start_new, output ready);
endinterface

interface sis_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [5:0] found_index;
  modport source (output valid, status, found_index, input ready);
  modport sink (input valid, status, found_index, output ready);
endinterface
`default_nettype wire

[hw/rtl/sorted_interpolation_search_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_interpolation_search_core: sorted store with interpolation search
// Usage: items arrive on in_ch, one result per item leaves on out_ch.
// A load appends value to the element store (start_new empties it first) and
// answers stored, or store full when no room is left. A search Shell-sorts
// the store in place, checks that all neighbouring steps are equal and then
// runs interpolation search for value.
// A search reads the two values of each sort compare one after the other
// through the single memory read port, and the uniformity scan reads the
// store one element at a time. A probe whose end values differ waits on
// the bit-serial divider.
// One item is handled at a time; in_ch.ready is low from acceptance until
// the result has been taken on out_ch. A stalled receiver holds the result
// and the next item waits behind it.
// Reset empties the store and clears both channels; no clearing pass.
// ----------------------------------------------------------------------------
module sorted_interpolation_search_core
  import sis_pkg::*;
#(
  parameter int unsigned MaxElements = DefaultMaxElements
) (
  input  wire logic clk,
  input  wire logic rst,
  sis_in_if.sink    in_ch,
  sis_out_if.source out_ch
);
  localparam int unsigned AddrWidth = $clog2(MaxElements);
  localparam int unsigned CntWidth = $clog2(MaxElements + 1);
  localparam int unsigned NumWidth = CntWidth + 33;
  localparam logic signed [CntWidth:0] IdxOne = (CntWidth+1)'(1);

  typedef enum logic [4:0] {
    S_IDLE, S_GAP, S_JLOOP, S_RDA, S_RDB, S_CMP, S_SWAP2,
    S_UNI0, S_UNI1, S_UNI2, S_UNIW,
    S_SLO, S_SHI, S_SCHK, S_SVHI, S_DIV, S_DIVW, S_PRD, S_PCHK, S_OUT
  } state_t;

  state_t state;
  logic signed [31:0] mem [MaxElements];
  logic signed [31:0] rdata;
  logic [AddrWidth-1:0] raddr;
  logic                 wen;
  logic [AddrWidth-1:0] waddr;
  logic signed [31:0]   wdata;

  logic [CntWidth-1:0] count;
  logic [CntWidth-1:0] gap;
  logic [CntWidth-1:0] jj;
  logic signed [CntWidth:0] ii;
  logic signed [31:0] va;
  logic signed [31:0] vb;
  logic signed [31:0] target;
  logic signed [32:0] step;
  logic [CntWidth-1:0] idx;
  logic signed [CntWidth:0] lo;
  logic signed [CntWidth:0] hi;
  logic signed [31:0] vlo;
  logic signed [31:0] vhi;
  logic [CntWidth-1:0] mid;
  logic [2:0] status;
  logic [5:0] found;
  logic out_valid;

  logic div_start;
  logic div_done;
  logic [NumWidth-1:0] div_num;
  logic [32:0] div_den;
  logic [NumWidth-1:0] div_q;
  logic [32:0] tdiff;
  logic [CntWidth-1:0] ispan;

  always_ff @(posedge clk) begin
    if (wen) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  assign tdiff = 33'(target) - 33'(vlo);
  assign ispan = CntWidth'(hi - lo);

  sis_div #(.NumWidth(NumWidth), .DenWidth(33)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .numer(div_num),
    .denom(div_den), .done(div_done), .quot(div_q)
  );

  assign in_ch.ready = (state == S_IDLE) && !out_valid;
  assign out_ch.valid = out_valid;
  assign out_ch.status = status;
  assign out_ch.found_index = found;

  always_ff @(posedge clk) begin
    wen <= 1'b0;
    div_start <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ch.ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            target <= in_ch.value;
            found <= '0;
            if (in_ch.operation == OP_LOAD) begin
              if (!in_ch.start_new && count == CntWidth'(MaxElements)) begin
                status <= ST_FULL;
              end else begin
                wen <= 1'b1;
                wdata <= in_ch.value;
                waddr <= in_ch.start_new ? '0 : AddrWidth'(count);
                count <= in_ch.start_new ? CntWidth'(1) : count + 1'b1;
                status <= ST_STORED;
              end
              state <= S_OUT;
            end else begin
              gap <= count >> 1;
              state <= S_GAP;
            end
          end
        end
        S_GAP: begin
          if (gap == '0) begin
            idx <= '0;
            state <= S_UNI0;
          end else begin
            jj <= gap;
            state <= S_JLOOP;
          end
        end
        S_JLOOP: begin
          if (jj >= count) begin
            gap <= gap >> 1;
            state <= S_GAP;
          end else begin
            ii <= $signed({1'b0, jj}) - $signed({1'b0, gap});
            state <= S_RDA;
          end
        end
        S_RDA: begin
          if (ii < 0) begin
            jj <= jj + 1'b1;
            state <= S_JLOOP;
          end else begin
            raddr <= AddrWidth'(ii);
            state <= S_RDB;
          end
        end
        S_RDB: begin
          raddr <= AddrWidth'(ii + $signed({1'b0, gap}));
          state <= S_CMP;
        end
        S_CMP: begin
          va <= rdata;
          state <= S_SWAP2;
        end
        S_SWAP2: begin
          if (rdata < va) begin
            wen <= 1'b1;
            waddr <= AddrWidth'(ii);
            wdata <= rdata;
            vb <= va;
            state <= S_UNIW;
          end else begin
            jj <= jj + 1'b1;
            state <= S_JLOOP;
          end
        end
        S_UNIW: begin
          if (gap != '0) begin
            wen <= 1'b1;
            waddr <= AddrWidth'(ii + $signed({1'b0, gap}));
            wdata <= vb;
            ii <= ii - $signed({1'b0, gap});
            state <= S_RDA;
          end
        end
        S_UNI0: begin
          if (count < CntWidth'(2)) begin
            lo <= '0;
            hi <= $signed({1'b0, count}) - IdxOne;
            state <= S_SLO;
          end else begin
            raddr <= '0;
            state <= S_UNI1;
          end
        end
        S_UNI1: state <= S_UNI2;
        S_UNI2: begin
          if (idx == '0) begin
            va <= rdata;
            idx <= CntWidth'(1);
            raddr <= AddrWidth'(1);
            state <= S_UNI1;
          end else if (idx >= CntWidth'(2) &&
                       (33'(rdata) - 33'(va)) != step) begin
            status <= ST_NOT_UNIFORM;
            state <= S_OUT;
          end else begin
            va <= rdata;
            if (idx == CntWidth'(1)) step <= 33'(rdata) - 33'(va);
            if (idx + 1'b1 >= count) begin
              lo <= '0;
              hi <= $signed({1'b0, count}) - IdxOne;
              state <= S_SLO;
            end else begin
              idx <= idx + 1'b1;
              raddr <= AddrWidth'(idx + 1'b1);
              state <= S_UNI1;
            end
          end
        end
        S_SLO: begin
          if (lo > hi) begin
            status <= ST_NOT_FOUND;
            state <= S_OUT;
          end else begin
            raddr <= AddrWidth'(lo);
            state <= S_SHI;
          end
        end
        S_SHI: begin
          raddr <= AddrWidth'(hi);
          state <= S_SCHK;
        end
        S_SCHK: begin
          vlo <= rdata;
          state <= S_SVHI;
        end
        S_SVHI: begin
          vhi <= rdata;
          state <= S_DIV;
        end
        S_DIV: begin
          if (target < vlo || target > vhi) begin
            status <= ST_NOT_FOUND;
            state <= S_OUT;
          end else if (vhi == vlo) begin
            mid <= CntWidth'(lo);
            raddr <= AddrWidth'(lo);
            state <= S_PRD;
          end else begin
            div_num <= NumWidth'(ispan) * NumWidth'(tdiff);
            div_den <= 33'(vhi) - 33'(vlo);
            div_start <= 1'b1;
            state <= S_DIVW;
          end
        end
        S_DIVW: begin
          if (div_done) begin
            mid <= CntWidth'(lo) + CntWidth'(div_q);
            raddr <= AddrWidth'(CntWidth'(lo) + CntWidth'(div_q));
            state <= S_PRD;
          end
        end
        S_PRD: state <= S_PCHK;
        S_PCHK: begin
          if (rdata == target) begin
            status <= ST_FOUND;
            found <= 6'(mid);
            state <= S_OUT;
          end else begin
            if (rdata < target) lo <= $signed({1'b0, mid}) + IdxOne;
            else hi <= $signed({1'b0, mid}) - IdxOne;
            state <= S_SLO;
          end
        end
        S_OUT: begin
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CntWidth'(MaxElements)) else $error("count overflow");
  a_busy_no_ready: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !in_ch.ready) else $error("ready while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ch.ready |=> out_valid && $stable(status))
    else $error("result dropped");
  a_found_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_FOUND |-> found == '0) else $error("stray index");
`endif
endmodule
`default_nettype wire

[hw/rtl/sis_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sis_div: restoring divider
// Unsigned division, one quotient bit a cycle, for the interpolation probe.
// ----------------------------------------------------------------------------
module sis_div
  import sis_pkg::*;
#(
  parameter int unsigned NumWidth = 48,
  parameter int unsigned DenWidth = 33
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [NumWidth-1:0] numer,
  input  wire logic [DenWidth-1:0] denom,
  output logic                     done,
  output logic [NumWidth-1:0]      quot
);
  localparam int unsigned CntWidth = $clog2(NumWidth + 1);

  logic [NumWidth-1:0] num;
  logic [DenWidth-1:0] den;
  logic [DenWidth:0]   rem;
  logic [CntWidth-1:0] cnt;
  logic                busy;
  logic [DenWidth:0]   shifted;
  logic [DenWidth:0]   diff;

  assign shifted = {rem[DenWidth-1:0], num[NumWidth-1]};
  assign diff = shifted - {1'b0, den};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      num <= numer;
      den <= denom;
      rem <= '0;
      cnt <= CntWidth'(NumWidth);
    end else if (busy) begin
      if (!diff[DenWidth]) begin
        rem <= diff;
        num <= {num[NumWidth-2:0], 1'b1};
      end else begin
        rem <= shifted;
        num <= {num[NumWidth-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CntWidth'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign quot = num;
endmodule
`default_nettype wire
